[rtl/huffman_code_bit_packer_defines.svh]
// ----------------------------------------------------------------------------
// Huffman code bit packer: assertion macros
// Shared assertion forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// Checks that a condition implies an expression in the same cycle.
`define HCBP_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Checks that a condition implies an expression in the following cycle.
`define HCBP_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

[rtl/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Widths, command codes and the types shared by the packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  // Field widths of the input and result beats.
  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int PAD_W  = 3;

  // Pending bits kept between symbols (at most seven) and their count.
  localparam int PEND_W = 3;
  localparam int TAIL_W = 7;

  // Widest merged word: seven pending bits plus one full code word.
  localparam int ACC_W = CODE_W + TAIL_W;

  // Bytes that one symbol can complete, and the width of that count.
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = 3;

  // Parameter defaults.
  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int ALPHABET_SIZE_DEF = 256;

  // Commands carried by an input beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  // One code table entry: saturated length and masked code word.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] word;
  } tbl_entry_t;

  // Registered lookup result handed from the code table to the packer.
  typedef struct packed {
    logic       miss;
    tbl_entry_t entry;
  } lookup_t;

endpackage

`default_nettype wire

[rtl/hcbp_if.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer channels
// Valid/ready channels for command beats in and packed byte beats out.
// ----------------------------------------------------------------------------
`default_nettype none

// Command channel: table loads, symbols to encode and flushes.
interface hcbp_item_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, command, symbol, code_bits, code_length,
                  input ready);
  modport sink   (input valid, command, symbol, code_bits, code_length,
                  output ready);
endinterface

// Result channel: one packed byte or one error per beat.
interface hcbp_result_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;
  logic [PAD_W-1:0]  pad_bits;
  logic              error;

  modport source (output valid, out_byte, last_of_run, pad_bits, error,
                  input ready);
  modport sink   (input valid, out_byte, last_of_run, pad_bits, error,
                  output ready);
endinterface

`default_nettype wire

[rtl/hcbp_code_table.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer code table
// Per-symbol code memory with registered read and reset-cleared
// entry valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_code_table import hcbp_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [SYM_W-1:0] wr_sym,
  input  tbl_entry_t       wr_entry,
  input  logic             rd_en,
  input  logic [SYM_W-1:0] rd_sym,
  output lookup_t          rd_data
);

  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W+1)'(ALPHABET_SIZE);

  tbl_entry_t               mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid;

  logic          wr_in_range;
  logic          rd_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Symbols beyond the alphabet never touch the memory.
  assign wr_in_range = {1'b0, wr_sym} < SYM_LIMIT;
  assign rd_in_range = {1'b0, rd_sym} < SYM_LIMIT;
  assign wr_addr     = wr_sym[AW-1:0];
  assign rd_addr     = rd_sym[AW-1:0];

  // A zero length marks the entry as having no code.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en && wr_in_range) begin
      valid[wr_addr] <= (wr_entry.len != '0);
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Registered read; a miss covers both unknown symbols and empty entries.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.miss <= !rd_in_range || !valid[rd_addr];
      if (rd_in_range) begin
        rd_data.entry <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/huffman_code_bit_packer.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Encoder back end: a loadable per-symbol code table feeding a byte packer.
// ----------------------------------------------------------------------------
// The block takes one command beat per cycle while its lookup stage can
// retire. A load writes the code table and gives no result; an encode reads
// the table (registered read) and merges the code behind the pending bits, or
// gives an error beat if the symbol has no code, and a flush emits the padded
// tail if any bits are pending. Results leave from an output register at one
// byte per cycle while the result side is ready, and an item with results
// waits in the lookup stage until the output register frees up; items with no
// or one result run at one beat per cycle when the result side does not stall.
// The first result is offered from the output register after the item's table
// read has passed the lookup stage. Loads write the table at acceptance, so a
// symbol may be encoded in the very next beat after its entry is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hcbp_item_if.sink   item,
  hcbp_result_if.source result
);

  localparam int LEN_LIMIT = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_LIMIT);

  // Input side.
  logic              accept;
  cmd_t              cmd;
  logic [LEN_W-1:0]  sat_len;
  logic [CODE_W-1:0] len_mask;
  tbl_entry_t        wr_entry;
  logic              wr_en;
  logic              rd_en;
  lookup_t           lookup;

  // Lookup stage.
  logic              s1_valid;
  logic              s1_flush;
  logic              s1_retire;
  logic [CNT_W-1:0]  s1_cnt;
  logic [CODE_W-1:0] s1_buf;
  logic [PAD_W-1:0]  s1_pad;
  logic              s1_err;

  // Pending bits carried between symbols.
  logic [TAIL_W-1:0] acc;
  logic [PEND_W-1:0] pend;
  logic [TAIL_W-1:0] acc_next;
  logic [PEND_W-1:0] pend_next;

  // Merge of pending bits and the looked-up code.
  logic [ACC_W-1:0]  merged;
  logic [LEN_W-1:0]  total;
  logic [CNT_W-1:0]  nbytes;
  logic [ACC_W-1:0]  merged_rest;

  // Output register.
  logic [CNT_W-1:0]  e_cnt;
  logic [CODE_W-1:0] e_buf;
  logic [PAD_W-1:0]  e_pad;
  logic              e_err;
  logic              e_free;
  logic              out_take;

  assign accept = item.valid && item.ready;
  assign cmd    = cmd_t'(item.command);
  assign wr_en  = accept && (cmd == CMD_LOAD);
  assign rd_en  = accept && (cmd == CMD_ENCODE);

  // Saturate the length and clear code bits beyond it before storing.
  assign sat_len  = (item.code_length > LEN_MAX) ? LEN_MAX : item.code_length;
  assign len_mask = CODE_W'(((CODE_W+1)'(1) << sat_len) - (CODE_W+1)'(1));
  assign wr_entry = '{len: sat_len, word: item.code_bits & len_mask};

  hcbp_code_table #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_sym   (item.symbol),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_sym   (item.symbol),
    .rd_data  (lookup)
  );

  // Lookup stage occupancy; loads and unused commands never enter it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && (cmd == CMD_ENCODE || cmd == CMD_FLUSH)) begin
      s1_valid <= 1'b1;
    end else if (s1_retire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush <= (cmd == CMD_FLUSH);
    end
  end

  // Append the code behind the pending bits and split off whole bytes.
  assign merged      = ACC_W'(acc) | (ACC_W'(lookup.entry.word) << pend);
  assign total       = LEN_W'(pend) + lookup.entry.len;
  assign nbytes      = total[LEN_W-1:PEND_W];
  assign merged_rest = merged >> {nbytes, 3'b000};

  // Results and the new pending state for the item in the lookup stage.
  always_comb begin
    s1_cnt    = '0;
    s1_buf    = '0;
    s1_pad    = '0;
    s1_err    = 1'b0;
    acc_next  = acc;
    pend_next = pend;
    priority if (s1_flush) begin
      s1_cnt    = (pend != '0) ? CNT_W'(1) : '0;
      s1_buf    = CODE_W'(acc);
      s1_pad    = PAD_W'(4'd8 - {1'b0, pend});
      acc_next  = '0;
      pend_next = '0;
    end else if (lookup.miss) begin
      s1_cnt = CNT_W'(1);
      s1_err = 1'b1;
    end else begin
      s1_cnt    = nbytes;
      s1_buf    = merged[CODE_W-1:0];
      acc_next  = merged_rest[TAIL_W-1:0];
      pend_next = total[PEND_W-1:0];
    end
  end

  // An item leaves the lookup stage when it has no result or the output
  // register frees up in this cycle.
  assign out_take  = result.valid && result.ready;
  assign e_free    = (e_cnt == '0) || (e_cnt == CNT_W'(1) && result.ready);
  assign s1_retire = s1_valid && ((s1_cnt == '0) || e_free);
  assign item.ready = !s1_valid || s1_retire;

  // Pending bit state.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      pend <= '0;
    end else if (s1_retire) begin
      acc  <= acc_next;
      pend <= pend_next;
    end
  end

  // Output register count.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_cnt <= '0;
    end else if (s1_retire && s1_cnt != '0) begin
      e_cnt <= s1_cnt;
    end else if (out_take) begin
      e_cnt <= e_cnt - CNT_W'(1);
    end
  end

  // Output register payload; bytes leave from the low end.
  always_ff @(posedge clk) begin
    if (s1_retire && s1_cnt != '0) begin
      e_buf <= s1_buf;
      e_pad <= s1_pad;
      e_err <= s1_err;
    end else if (out_take) begin
      e_buf <= e_buf >> BYTE_W;
    end
  end

  assign result.valid       = (e_cnt != '0);
  assign result.out_byte    = e_buf[BYTE_W-1:0];
  assign result.last_of_run = (e_cnt == CNT_W'(1));
  assign result.pad_bits    = e_pad;
  assign result.error       = e_err;

  // Checks.
  `HCBP_ASSERT_NOW(a_cnt_bound, 1'b1, e_cnt <= CNT_W'(MAX_RESULTS),
    "output register holds more bytes than one symbol can complete")
  `HCBP_ASSERT_NEXT(a_flush_clears, s1_retire && s1_flush, pend == '0 && acc == '0,
    "pending bits survive a flush")
  `HCBP_ASSERT_NEXT(a_miss_keeps, s1_retire && !s1_flush && lookup.miss,
    $stable(acc) && $stable(pend), "a symbol without a code changed the pending bits")
  `HCBP_ASSERT_NOW(a_pad_last, result.valid && result.pad_bits != '0,
    result.last_of_run && !result.error, "padded byte is not a final flush beat")

endmodule

`default_nettype wire
